[design/sha512_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

   localparam int unsigned WordW    = 64;
   localparam int unsigned Rounds   = 80;
   localparam int unsigned BlkWords = 16;
   localparam int unsigned HashW    = 8;
   localparam int unsigned RndW     = 7;
   localparam int unsigned PosW     = 4;
   localparam int unsigned CntW     = 128;

   localparam logic [PosW-1:0] PosLenHi = 4'd14;
   localparam logic [PosW-1:0] PosLast  = 4'd15;
   localparam logic [3:0]      FullBytes = 4'd8;
   localparam logic [7:0]      PadByte  = 8'h80;
   localparam logic [2:0]      LastIdx512 = 3'd7;
   localparam logic [2:0]      LastIdx384 = 3'd5;
   localparam logic            Mode512  = 1'b0;
   localparam logic            Mode384  = 1'b1;

   // control from the sequencer to the compression core
   typedef struct packed {
      logic push;
      logic start;
      logic init;
      logic mode;
   } core_ctl_type;

   typedef logic [WordW-1:0] word_type;

   function automatic word_type ror64(input word_type x, input int unsigned n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type initial_hash(input logic mode, input logic [2:0] i);
      word_type r;
      r = '0;
      if (mode == Mode384) begin
         case (i)
            3'd0: r = 64'hcbbb9d5dc1059ed8;
            3'd1: r = 64'h629a292a367cd507;
            3'd2: r = 64'h9159015a3070dd17;
            3'd3: r = 64'h152fecd8f70e5939;
            3'd4: r = 64'h67332667ffc00b31;
            3'd5: r = 64'h8eb44a8768581511;
            3'd6: r = 64'hdb0c2e0d64f98fa7;
            default: r = 64'h47b5481dbefa4fa4;
         endcase
      end else begin
         case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
         endcase
      end
      initial_hash = r;
   endfunction

   function automatic word_type round_k(input logic [RndW-1:0] i);
      word_type r;
      r = '0;
      case (i)
         7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
         7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
         7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
         7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
         7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
         7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
         7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
         7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
         7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
         7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
         7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
         7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
         7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
         7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
         7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
         7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
         7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
         7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
         7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
         7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
         7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
         7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
         7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
         7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
         7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
         7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
         7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
         7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
         7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
         7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
         7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
         7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
         7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
         7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
         7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
         7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
         7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
         7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
         7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
         7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
         default: r = '0;
      endcase
      round_k = r;
   endfunction

endpackage
`default_nettype wire

[design/sha512_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha512_core
   import sha512_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire core_ctl_type ctl,
   input  wire word_type     word,
   output logic              busy,
   output word_type          hash [HashW]
);

   word_type          win_ff  [BlkWords];
   word_type          vars_ff [HashW];
   word_type          hash_ff [HashW];
   logic [RndW-1:0]   rnd_ff;
   logic              run_ff;

   word_type w_next, s0, s1, t1, t2, ch, maj, e_sum, a_sum;

   // message schedule: win[k] holds W[t+k] at round t
   always_comb begin
      s0 = ror64(win_ff[1], 1) ^ ror64(win_ff[1], 8) ^ (win_ff[1] >> 7);
      s1 = ror64(win_ff[14], 19) ^ ror64(win_ff[14], 61) ^ (win_ff[14] >> 6);
      w_next = s1 + win_ff[9] + s0 + win_ff[0];
   end

   // one round of the compression
   always_comb begin
      e_sum = ror64(vars_ff[4], 14) ^ ror64(vars_ff[4], 18) ^ ror64(vars_ff[4], 41);
      a_sum = ror64(vars_ff[0], 28) ^ ror64(vars_ff[0], 34) ^ ror64(vars_ff[0], 39);
      ch    = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      maj   = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]);
      t1 = vars_ff[7] + e_sum + ch + round_k(rnd_ff) + win_ff[0];
      t2 = a_sum + maj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         rnd_ff <= '0;
         for (int i = 0; i < HashW; i++) begin
            hash_ff[i] <= initial_hash(Mode512, 3'(i));
            vars_ff[i] <= '0;
         end
      end else if (run_ff) begin
         if (rnd_ff == RndW'(Rounds)) begin
            // feed-forward of the block result
            for (int i = 0; i < HashW; i++)
               hash_ff[i] <= hash_ff[i] + vars_ff[i];
            run_ff <= 1'b0;
            rnd_ff <= '0;
         end else begin
            for (int i = 0; i < BlkWords - 1; i++)
               win_ff[i] <= win_ff[i+1];
            win_ff[BlkWords-1] <= w_next;
            vars_ff[7] <= vars_ff[6];
            vars_ff[6] <= vars_ff[5];
            vars_ff[5] <= vars_ff[4];
            vars_ff[4] <= vars_ff[3] + t1;
            vars_ff[3] <= vars_ff[2];
            vars_ff[2] <= vars_ff[1];
            vars_ff[1] <= vars_ff[0];
            vars_ff[0] <= t1 + t2;
            rnd_ff <= rnd_ff + 1'b1;
         end
      end else begin
         if (ctl.push) begin
            for (int i = 0; i < BlkWords - 1; i++)
               win_ff[i] <= win_ff[i+1];
            win_ff[BlkWords-1] <= word;
         end
         if (ctl.start) begin
            for (int i = 0; i < HashW; i++)
               vars_ff[i] <= hash_ff[i];
            run_ff <= 1'b1;
            rnd_ff <= '0;
         end
         if (ctl.init) begin
            for (int i = 0; i < HashW; i++)
               hash_ff[i] <= initial_hash(ctl.mode, 3'(i));
         end
      end
   end

   assign busy = run_ff;
   always_comb begin
      for (int i = 0; i < HashW; i++)
         hash[i] = hash_ff[i];
   end

endmodule
`default_nettype wire

[design/sha512_hash_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// SHA-512 / SHA-384 hash engine.
// req_ channel: one transaction per 64-bit big-endian message word. tlast marks
//   the final word of a message; its valid_bytes (0..8, left-aligned) is used,
//   values above 8 count as 8. Other words always count as 8 bytes.
// rsp_ channel: after a final word, 8 digest words (SHA-512) or 6 (SHA-384) in
//   order from most significant; tlast on the final one.
// csr_: writing csr_wdata selects the mode (0 SHA-512, 1 SHA-384) and starts a
//   fresh message; write only while the engine is idle.
// Flow: words are taken back to back while the engine is idle, except that the
//   sixteenth of a block runs the shared round unit for 80 rounds plus a
//   feed-forward step before the next word is accepted. The final word is
//   followed by the padding words and one or two block compressions before
//   the digest appears. req_tready is low throughout that time.
// The digest words are held until taken; a stalled receiver simply stretches
//   the output phase and no input is accepted meanwhile.
// Reset: selects SHA-512, loads its initial hash and clears the byte count.
module sha512_hash_engine
   import sha512_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // message_word[63:0], valid_bytes[67:64], zero
   input  wire logic        req_tlast,  // last_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // digest_word[63:0], word_index[66:64], zero
   output logic             rsp_tlast,  // last_word
   input  wire logic        csr_we,
   input  wire logic        csr_wdata   // digest_mode
);

   typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_WAIT, ST_EMIT} state_type;

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [CntW-1:0]  bc_ff, bc_in;
   logic             first_ff, first_in;
   logic             lenok_ff, lenok_in;
   logic             final_ff, final_in;
   logic             pad_ff, pad_in;
   logic [2:0]       idx_ff, idx_in;

   core_ctl_type     ctl;
   word_type         push_word;
   logic             busy;
   word_type         hash [HashW];

   logic [3:0]       nbytes;
   logic [CntW-1:0]  bits;
   logic             last_out;

   sha512_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .word  (push_word),
      .busy  (busy),
      .hash  (hash)
   );

   // final word: keep valid bytes, place the padding byte, zero the rest
   function automatic word_type pad_last(input word_type w, input logic [3:0] n);
      word_type r;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < n)       r[63-8*b -: 8] = w[63-8*b -: 8];
         else if (4'(b) == n) r[63-8*b -: 8] = PadByte;
         else                 r[63-8*b -: 8] = '0;
      end
      pad_last = r;
   endfunction

   assign nbytes   = (req_tdata[67:64] > FullBytes) ? FullBytes : req_tdata[67:64];
   assign bits     = bc_ff << 3;
   assign last_out = idx_ff == ((mode_ff == Mode384) ? LastIdx384 : LastIdx512);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      bc_in     = bc_ff;
      first_in  = first_ff;
      lenok_in  = lenok_ff;
      final_in  = final_ff;
      pad_in    = pad_ff;
      idx_in    = idx_ff;
      ctl       = '0;
      ctl.mode  = mode_ff;
      push_word = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.push = 1'b1;
               pos_in   = pos_ff + 1'b1;
               if (!req_tlast) begin
                  bc_in     = bc_ff + CntW'(FullBytes);
                  push_word = req_tdata[63:0];
               end else begin
                  bc_in  = bc_ff + CntW'(nbytes);
                  pad_in = 1'b1;
                  state_in = ST_PAD;
                  if (nbytes == FullBytes) begin
                     push_word = req_tdata[63:0];
                     first_in  = 1'b1;
                  end else begin
                     push_word = pad_last(req_tdata[63:0], nbytes);
                     first_in  = 1'b0;
                     lenok_in  = pos_ff != PosLenHi;
                  end
               end
               if (pos_ff == PosLast) begin
                  ctl.start = 1'b1;
                  final_in  = 1'b0;
                  state_in  = ST_WAIT;
               end
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            pos_in   = pos_ff + 1'b1;
            first_in = 1'b0;
            if (first_ff) begin
               push_word = {PadByte, 56'd0};
               lenok_in  = pos_ff != PosLenHi;
            end else if (lenok_ff && pos_ff == PosLenHi) begin
               push_word = bits[127:64];
            end else if (lenok_ff && pos_ff == PosLast) begin
               push_word = bits[63:0];
            end
            if (pos_ff == PosLast) begin
               ctl.start = 1'b1;
               state_in  = ST_WAIT;
               if (!first_ff && lenok_ff) final_in = 1'b1;
               else                       lenok_in = 1'b1;
            end
         end
         ST_WAIT: begin
            if (!busy) begin
               if (final_ff) begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end else if (pad_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (last_out) begin
                  ctl.init = 1'b1;
                  bc_in    = '0;
                  pos_in   = '0;
                  pad_in   = 1'b0;
                  final_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // mode write restarts the message
      if (csr_we) begin
         mode_in  = csr_wdata;
         ctl.init = 1'b1;
         ctl.mode = csr_wdata;
         bc_in    = '0;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= Mode512;
         pos_ff   <= '0;
         bc_ff    <= '0;
         first_ff <= 1'b0;
         lenok_ff <= 1'b0;
         final_ff <= 1'b0;
         pad_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         bc_ff    <= bc_in;
         first_ff <= first_in;
         lenok_ff <= lenok_in;
         final_ff <= final_in;
         pad_ff   <= pad_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_EMIT;
   assign rsp_tdata  = {5'd0, idx_ff, hash[idx_ff]};
   assign rsp_tlast  = last_out;

endmodule
`default_nettype wire

[design/sha512_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha512_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // never taking input while a digest is being delivered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input ready during digest output");

   // nothing to deliver straight after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("digest valid after reset");

   // final word is index 7 or 5
   a_lastidx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[66:64] == 3'd7 || rsp_tdata[66:64] == 3'd5))
      else $error("bad final digest index");

   // digest words follow one another without gaps
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[66:64] == $past(rsp_tdata[66:64]) + 3'd1)
      else $error("digest index sequence broken");

   // stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled digest changed");

endmodule

bind sha512_hash_engine sha512_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[tb/tb_sha512_hash_engine.sv]
`timescale 1ns / 1ps
module tb_sha512_hash_engine;
   import sha512_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_wdata;

   sha512_hash_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } msg_item_t;

   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  idx;
      logic        last;
   } digest_item_t;

   localparam longint unsigned CycleLimit = 2000000;

   msg_item_t    pending_words[$];
   digest_item_t expected_digest[$];
   int           error_count;
   int           digests_seen;
   longint unsigned cycle_count;
   int           send_wait;
   int           recv_wait;
   logic         driver_on;

   // predictor state
   logic        pr_mode;
   logic [63:0] pr_hash [8];
   logic [63:0] pr_block [16];
   logic [127:0] pr_bytes;
   int          pr_pos;

   // clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   function automatic logic [63:0] rot(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] start_hash(input logic m, input int i);
      logic [63:0] iv512 [8];
      logic [63:0] iv384 [8];
      iv512 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      iv384 = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
                64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
                64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      return (m == Mode384) ? iv384[i] : iv512[i];
   endfunction

   function automatic logic [63:0] k_const(input int i);
      logic [63:0] kt [80];
      kt = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      return kt[i];
   endfunction

   task automatic new_message();
      for (int i = 0; i < 8; i++) pr_hash[i] = start_hash(pr_mode, i);
      pr_bytes = '0;
      pr_pos = 0;
   endtask

   // 80-round compression of the buffered block
   task automatic compress_block();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2, s0, s1;
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            w[r] = pr_block[r];
         end else begin
            s1 = rot(w[r-2], 19) ^ rot(w[r-2], 61) ^ (w[r-2] >> 6);
            s0 = rot(w[r-15], 1) ^ rot(w[r-15], 8) ^ (w[r-15] >> 7);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
         end
      end
      for (int i = 0; i < 8; i++) v[i] = pr_hash[i];
      for (int r = 0; r < 80; r++) begin
         t1 = v[7] + (rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + w[r];
         t2 = (rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) pr_hash[i] = pr_hash[i] + v[i];
   endtask

   task automatic buffer_word(input logic [63:0] w);
      pr_block[pr_pos] = w;
      pr_pos = (pr_pos + 1) % 16;
      if (pr_pos == 0) compress_block();
   endtask

   // predicts the digest transactions caused by one accepted message word
   task automatic predict_digest(input msg_item_t it);
      int n;
      int cnt;
      logic [63:0] w;
      digest_item_t d;
      if (!it.last) begin
         pr_bytes = pr_bytes + 128'd8;
         buffer_word(it.word);
         return;
      end
      n = (it.nbytes > 8) ? 8 : int'(it.nbytes);
      pr_bytes = pr_bytes + 128'(n);
      w = it.word;
      if (n == 8) begin
         buffer_word(w);
         w = {PadByte, 56'd0};
      end else if (n == 0) begin
         w = {PadByte, 56'd0};
      end else begin
         w = w & (~64'd0 << (64 - 8 * n));
         w = w | (64'(PadByte) << (56 - 8 * n));
      end
      buffer_word(w);
      if (pr_pos > 14 || pr_pos == 0) begin
         while (pr_pos != 0) buffer_word('0);
      end
      while (pr_pos < 14) buffer_word('0);
      buffer_word(pr_bytes[124:61]);
      buffer_word({pr_bytes[60:0], 3'b000});
      cnt = (pr_mode == Mode384) ? 6 : 8;
      for (int j = 0; j < cnt; j++) begin
         d.word = pr_hash[j];
         d.idx  = 3'(j);
         d.last = (j == cnt - 1);
         expected_digest.push_back(d);
      end
      new_message();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
   endtask

   function automatic msg_item_t mk_word(input logic [63:0] w, input int nb, input bit l);
      msg_item_t it;
      it.word = w;
      it.nbytes = 4'(nb);
      it.last = l;
      return it;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // driver: takes words from the pending queue, random gap after most accepted words
   always @(posedge clock) begin
      msg_item_t nxt;
      if (reset || !driver_on) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the offered transaction
      end else if (send_wait > 0) begin
         req_tvalid <= 1'b0;
         send_wait <= send_wait - 1;
      end else begin
         if (req_tvalid && req_tready) begin
            void'(pending_words.pop_front());
            predict_digest(mk_word(req_tdata[63:0], int'(req_tdata[67:64]), req_tlast));
         end
         if (req_tvalid && req_tready && pending_words.size() > 0 && ($urandom_range(0, 3) != 0))
         begin
            req_tvalid <= 1'b0;
            send_wait <= $urandom_range(0, 15);
         end else if (pending_words.size() > 0) begin
            nxt = pending_words[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, nxt.nbytes, nxt.word};
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      digest_item_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            digests_seen++;
            if (expected_digest.size() == 0) begin
               report_mismatch("unexpected digest word", rsp_tdata[63:0], '0);
            end else begin
               want = expected_digest.pop_front();
               if (rsp_tdata[63:0] !== want.word)
                  report_mismatch("digest_word", rsp_tdata[63:0], want.word);
               if (rsp_tdata[66:64] !== want.idx)
                  report_mismatch("word_index", 64'(rsp_tdata[66:64]), 64'(want.idx));
               if (rsp_tdata[71:67] !== 5'd0)
                  report_mismatch("tdata padding", 64'(rsp_tdata[71:67]), '0);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_word", 64'(rsp_tlast), 64'(want.last));
            end
         end
         if (recv_wait > 0) begin
            rsp_tready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else if (rsp_tvalid && rsp_tready && ($urandom_range(0, 2) == 0)) begin
            rsp_tready <= 1'b0;
            recv_wait <= $urandom_range(0, 15);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_tvalid || expected_digest.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      pr_mode = m;
      new_message();
   endtask

   task automatic queue_message(input int nwords, input int nb);
      for (int i = 0; i < nwords; i++) pending_words.push_back(mk_word(rnd64(), 8, 1'b0));
      pending_words.push_back(mk_word(rnd64(), nb, 1'b1));
   endtask

   initial begin
      int total;
      int nb;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0; csr_we = 1'b0; csr_wdata = 1'b0;
      driver_on = 1'b0;
      error_count = 0; digests_seen = 0;
      cycle_count = 0; send_wait = 0; recv_wait = 0;
      pr_mode = Mode512;
      new_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, short words, padding boundaries
      pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1));
      pending_words.push_back(mk_word(64'h6162_6300_0000_0000, 3, 1'b1)); // "abc"
      pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1));
      pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 15, 1'b1));
      pending_words.push_back(mk_word(64'h0, 7, 1'b1));
      // non-last word with odd byte count is taken as eight bytes
      pending_words.push_back(mk_word(64'h0123_4567_89AB_CDEF, 1, 1'b0));
      pending_words.push_back(mk_word(64'hFEDC_BA98_7654_3210, 1, 1'b1));
      queue_message(13, 7);  // padding fits
      queue_message(13, 8);  // spills to a second block
      driver_on = 1'b1;
      wait_idle();

      // directed in SHA-384 mode, including the buffer-full case
      write_mode(Mode384);
      queue_message(0, 5);
      queue_message(15, 8);
      queue_message(16, 0);
      wait_idle();

      // mode write drops the message in progress
      queue_message(3, 8);
      void'(pending_words.pop_back());
      wait_idle();
      write_mode(Mode512);
      queue_message(2, 4);
      wait_idle();
      write_mode(Mode512);

      // random messages, mostly short, mode rewritten at random between phases
      total = 0;
      for (int ph = 0; ph < 6; ph++) begin
         while (total < (ph + 1) * 55) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 6);
            nb = $urandom_range(0, 15);
            queue_message(len, nb);
            total += len + 1;
         end
         wait_idle();
         write_mode(1'($urandom_range(0, 1)));
      end

      $display("Hashed %0d message words, checked %0d digest words in both modes.",
               total + 75, digests_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
